### hdl/neighbor_average_pixel_map_top_defines.svh
// Assertion macros shared by the neighbor average pixel map RTL.
`ifndef NEIGHBOR_AVERAGE_PIXEL_MAP_TOP_DEFINES_SVH
`define NEIGHBOR_AVERAGE_PIXEL_MAP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define NAP_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("neighbor average pixel map check failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define NAP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("neighbor average pixel map check failed");

`endif

### hdl/nap_pkg.sv
// Shared constants, types and the reciprocal table of the neighbor average pixel map.
`timescale 1ns / 1ps

package nap_pkg;

   // Parameter defaults
   localparam int DEF_MAX_WIDTH    = 256;
   localparam int DEF_MAX_HEIGHT   = 256;
   localparam int DEF_CHANNEL_BITS = 8;

   // Coordinates and channels on the ports are 8 bits
   localparam int COORD_LIMIT   = 256;
   localparam int CHAN_OUT_BITS = 8;
   localparam int SIZE_BITS     = 9;
   localparam int COUNT_BITS    = 4;
   // Nine channels of at most 255 plus the rounding half fit in 12 bits
   localparam int SUM_BITS      = 12;
   // Reciprocal 2^16/n rounded up is exact for sums below 2^12 and n up to 9
   localparam int RECIP_BITS    = 17;
   localparam int RECIP_SHIFT   = 16;
   localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;

   // Commands
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_EXPAND = 2'd2;

   // Pixel status
   localparam logic [1:0] STATUS_BLANK = 2'd0;
   localparam logic [1:0] STATUS_SET   = 2'd1;

   // Register indexes
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef struct packed {
      logic [SUM_BITS-1:0] red;
      logic [SUM_BITS-1:0] green;
      logic [SUM_BITS-1:0] blue;
   } chan_sums_type;

   typedef struct packed {
      logic [CHAN_OUT_BITS-1:0] red;
      logic [CHAN_OUT_BITS-1:0] green;
      logic [CHAN_OUT_BITS-1:0] blue;
   } chan_avg_type;

   // ceil(2^16 / n); zero for a count of zero gives a black result
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         4'd1: r = 17'd65536;
         4'd2: r = 17'd32768;
         4'd3: r = 17'd21846;
         4'd4: r = 17'd16384;
         4'd5: r = 17'd13108;
         4'd6: r = 17'd10923;
         4'd7: r = 17'd9363;
         4'd8: r = 17'd8192;
         4'd9: r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### hdl/nap_pixel_mem.sv
// Pixel memory: one synchronous read port, one write port, clearing pass after reset.
`timescale 1ns / 1ps

module nap_pixel_mem #(
   parameter int ADDR_BITS = 16,
   parameter int WORD_BITS = 26
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   output logic                 clear_busy
);
   import nap_pkg::*;

   localparam int Depth = 1 << ADDR_BITS;

   logic [WORD_BITS-1:0] pixel_ram [Depth];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS:0]   clr_addr_ff, clr_addr_in;

   // Sweep counter: top bit set once every entry has been cleared
   assign clear_busy  = ~clr_addr_ff[ADDR_BITS];
   assign clr_addr_in = clear_busy ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Write port: clearing pass has priority
   always_ff @(posedge clock) begin
      if (clear_busy) begin
         pixel_ram[clr_addr_ff[ADDR_BITS-1:0]] <= '0;
      end else if (wr_en) begin
         pixel_ram[wr_addr] <= wr_data;
      end
   end

   // Read port, registered, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pixel_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/nap_avg.sv
// Rounded average of three channel sums by a count of 0 to 9, via reciprocal multiply.
`timescale 1ns / 1ps

module nap_avg (
   input  logic                                clock,
   input  logic                                start,
   input  nap_pkg::chan_sums_type              sums,
   input  logic [nap_pkg::COUNT_BITS-1:0]      count,
   output nap_pkg::chan_avg_type               avg
);
   import nap_pkg::*;

   logic [RECIP_BITS-1:0] recip;
   logic [SUM_BITS-1:0]   half;
   logic [SUM_BITS-1:0]   red_biased, green_biased, blue_biased;
   logic [PROD_BITS-1:0]  prod_red_ff, prod_red_in;
   logic [PROD_BITS-1:0]  prod_green_ff, prod_green_in;
   logic [PROD_BITS-1:0]  prod_blue_ff, prod_blue_in;

   // Bias by half the count for round-half-up, then scale by 2^16/n
   assign recip        = recip_of(count);
   assign half         = SUM_BITS'(count[COUNT_BITS-1:1]);
   assign red_biased   = sums.red + half;
   assign green_biased = sums.green + half;
   assign blue_biased  = sums.blue + half;

   assign prod_red_in   = start ? PROD_BITS'(red_biased) * PROD_BITS'(recip) : prod_red_ff;
   assign prod_green_in = start ? PROD_BITS'(green_biased) * PROD_BITS'(recip)
                                : prod_green_ff;
   assign prod_blue_in  = start ? PROD_BITS'(blue_biased) * PROD_BITS'(recip) : prod_blue_ff;

   always_ff @(posedge clock) begin
      prod_red_ff   <= prod_red_in;
      prod_green_ff <= prod_green_in;
      prod_blue_ff  <= prod_blue_in;
   end

   // Quotient is the product shifted down
   assign avg.red   = prod_red_ff[RECIP_SHIFT +: CHAN_OUT_BITS];
   assign avg.green = prod_green_ff[RECIP_SHIFT +: CHAN_OUT_BITS];
   assign avg.blue  = prod_blue_ff[RECIP_SHIFT +: CHAN_OUT_BITS];

endmodule

### hdl/neighbor_average_pixel_map_top.sv
// Top level of the neighbor average pixel map: command sequencer, registers, result register.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   command, x/y, color, status
//   rsp_      out        rsp_valid / rsp_ready   color avg, count, found, x/y, last
//   csr_      in         psel / penable / pready width_in_use (0x0), height_in_use (0x4)
//
// A write goes to memory at accept. A query runs from accept to next accept as nine window
// reads one a cycle, a drain of the read stage, the multiply, the result load and idle.
// An expand does the same without the multiply. Both wait in the last state while the result
// register is full; an expand also holds its scan when a second blank neighbor finds it full.
// After reset the memory is swept, one entry a cycle (2^(column bits + row bits) entries,
// 65536 at the defaults), before req_ready rises. Register writes are taken during the sweep.
`timescale 1ns / 1ps
`include "neighbor_average_pixel_map_top_defines.svh"

module neighbor_average_pixel_map_top #(
   parameter int MAX_WIDTH    = nap_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT   = nap_pkg::DEF_MAX_HEIGHT,
   parameter int CHANNEL_BITS = nap_pkg::DEF_CHANNEL_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_x_pos,
   input  logic [7:0]  req_y_pos,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [1:0]  req_status_in,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [3:0]  rsp_neighbor_count,
   output logic        rsp_found,
   output logic [7:0]  rsp_out_x,
   output logic [7:0]  rsp_out_y,
   output logic        rsp_last,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nap_pkg::*;

   localparam int ColLimit  = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
   localparam int RowLimit  = (MAX_HEIGHT < COORD_LIMIT) ? MAX_HEIGHT : COORD_LIMIT;
   localparam int ColBits   = $clog2(ColLimit);
   localparam int RowBits   = $clog2(RowLimit);
   localparam int AddrBits  = ColBits + RowBits;
   localparam int ChanW     = (CHANNEL_BITS < CHAN_OUT_BITS) ? CHANNEL_BITS : CHAN_OUT_BITS;
   localparam int WordBits  = 2 + 3 * ChanW;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_AVG,
      ST_FINISH
   } state_type;

   // Registers
   state_type                state_ff, state_in;
   logic [SIZE_BITS-1:0]     width_ff, width_in;
   logic [SIZE_BITS-1:0]     height_ff, height_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [7:0]               x_ff, x_in;
   logic [7:0]               y_ff, y_in;
   logic [1:0]               dxi_ff, dxi_in;
   logic [1:0]               dyi_ff, dyi_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     p_valid_ff, p_valid_in;
   logic                     p_inb_ff, p_inb_in;
   logic                     p_center_ff, p_center_in;
   logic [7:0]               p_nx_ff, p_nx_in;
   logic [7:0]               p_ny_ff, p_ny_in;
   chan_sums_type            sums_ff, sums_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [7:0]               pend_x_ff, pend_x_in;
   logic [7:0]               pend_y_ff, pend_y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   chan_avg_type             rsp_color_ff, rsp_color_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [7:0]               rsp_x_ff, rsp_x_in;
   logic [7:0]               rsp_y_ff, rsp_y_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Combinational
   logic [SIZE_BITS-1:0]     w_eff, h_eff;
   logic                     req_fire, out_free, csr_wr;
   logic [9:0]               nx, ny;
   logic                     inb, center, issue, stall, hit_set, hit_blank, push;
   logic                     scan_end;
   logic                     mem_rd_en, mem_wr_en, mem_busy;
   logic [AddrBits-1:0]      mem_rd_addr, mem_wr_addr;
   logic [WordBits-1:0]      mem_rd_data, mem_wr_data;
   logic [1:0]               rd_status;
   logic [ChanW-1:0]         rd_red, rd_green, rd_blue;
   chan_avg_type             avg;
   logic                     avg_start;

   // Map size in use, saturated to 1 .. limit
   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (width_ff > SIZE_BITS'(ColLimit)) begin
         w_eff = SIZE_BITS'(ColLimit);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (height_ff > SIZE_BITS'(RowLimit)) begin
         h_eff = SIZE_BITS'(RowLimit);
      end else begin
         h_eff = height_ff;
      end
   end

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = {23'd0, (csr_paddr[2] == CSR_IDX_HEIGHT) ? height_ff : width_ff};

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Pixel writes go straight to memory at accept
   assign mem_wr_en   = req_fire && (req_command == CMD_WRITE)
                        && ({1'b0, req_x_pos} < w_eff) && ({1'b0, req_y_pos} < h_eff);
   assign mem_wr_addr = {req_y_pos[RowBits-1:0], req_x_pos[ColBits-1:0]};
   assign mem_wr_data = {req_status_in, req_red_in[ChanW-1:0], req_green_in[ChanW-1:0],
                         req_blue_in[ChanW-1:0]};

   // Window position of the read being issued
   assign nx     = 10'(x_ff) + 10'(dxi_ff) - 10'd1;
   assign ny     = 10'(y_ff) + 10'(dyi_ff) - 10'd1;
   assign inb    = !nx[9] && (nx[8:0] < w_eff) && !ny[9] && (ny[8:0] < h_eff);
   assign center = (dxi_ff == 2'd1) && (dyi_ff == 2'd1);

   // Word returned for the previous read
   assign rd_status = mem_rd_data[WordBits-1 -: 2];
   assign rd_red    = mem_rd_data[3*ChanW-1 -: ChanW];
   assign rd_green  = mem_rd_data[2*ChanW-1 -: ChanW];
   assign rd_blue   = mem_rd_data[ChanW-1:0];

   assign hit_set   = p_valid_ff && p_inb_ff && (cmd_ff == CMD_QUERY)
                      && (rd_status == STATUS_SET);
   assign hit_blank = p_valid_ff && p_inb_ff && !p_center_ff && (cmd_ff == CMD_EXPAND)
                      && (rd_status == STATUS_BLANK);
   // Hold the scan while a held-back neighbor cannot move to the result register
   assign stall     = hit_blank && pend_valid_ff && !out_free;
   assign issue     = (state_ff == ST_SCAN) && !issue_done_ff && !stall;
   // All nine reads issued and the last one consumed
   assign scan_end  = (state_ff == ST_SCAN) && issue_done_ff && !p_valid_ff;

   assign mem_rd_en   = issue;
   assign mem_rd_addr = {ny[RowBits-1:0], nx[ColBits-1:0]};
   assign avg_start   = (state_ff == ST_AVG);

   nap_pixel_mem #(
      .ADDR_BITS (AddrBits),
      .WORD_BITS (WordBits)
   ) u_pixel_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data    (mem_rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .clear_busy (mem_busy)
   );

   nap_avg u_avg (
      .clock (clock),
      .start (avg_start),
      .sums  (sums_ff),
      .count (cnt_ff),
      .avg   (avg)
   );

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dxi_in        = dxi_ff;
      dyi_in        = dyi_ff;
      issue_done_in = issue_done_ff;
      sums_in       = sums_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      push          = 1'b0;
      rsp_color_in  = rsp_color_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;

      // register writes
      if (csr_wr) begin
         if (csr_paddr[2] == CSR_IDX_HEIGHT) begin
            height_in = csr_pwdata[SIZE_BITS-1:0];
         end else begin
            width_in = csr_pwdata[SIZE_BITS-1:0];
         end
      end

      // read stage bookkeeping
      p_valid_in  = stall ? p_valid_ff : issue;
      p_inb_in    = issue ? inb : p_inb_ff;
      p_center_in = issue ? center : p_center_ff;
      p_nx_in     = issue ? nx[7:0] : p_nx_ff;
      p_ny_in     = issue ? ny[7:0] : p_ny_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (!mem_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_QUERY || req_command == CMD_EXPAND)) begin
               cmd_in        = req_command;
               x_in          = req_x_pos;
               y_in          = req_y_pos;
               dxi_in        = '0;
               dyi_in        = '0;
               issue_done_in = 1'b0;
               sums_in       = '0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // dx outer, dy inner
            if (issue) begin
               if (dyi_ff == 2'd2) begin
                  dyi_in = '0;
                  dxi_in = dxi_ff + 2'd1;
                  if (dxi_ff == 2'd2) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  dyi_in = dyi_ff + 2'd1;
               end
            end
            // query accumulation
            if (hit_set) begin
               sums_in.red   = sums_ff.red + SUM_BITS'(rd_red);
               sums_in.green = sums_ff.green + SUM_BITS'(rd_green);
               sums_in.blue  = sums_ff.blue + SUM_BITS'(rd_blue);
               cnt_in        = cnt_ff + 4'd1;
            end
            // expand: keep one neighbor back so the final one can carry last
            if (hit_blank && !stall) begin
               if (pend_valid_ff) begin
                  push         = 1'b1;
                  rsp_color_in = '0;
                  rsp_count_in = '0;
                  rsp_found_in = 1'b1;
                  rsp_x_in     = pend_x_ff;
                  rsp_y_in     = pend_y_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_x_in     = p_nx_ff;
               pend_y_in     = p_ny_ff;
            end
            if (scan_end) begin
               state_in = (cmd_ff == CMD_QUERY) ? ST_AVG : ST_FINISH;
            end
         end
         ST_AVG: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               push        = 1'b1;
               rsp_last_in = 1'b1;
               if (cmd_ff == CMD_QUERY) begin
                  rsp_color_in = avg;
                  rsp_count_in = cnt_ff;
                  rsp_found_in = 1'b0;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
               end else begin
                  rsp_color_in = '0;
                  rsp_count_in = '0;
                  rsp_found_in = pend_valid_ff;
                  rsp_x_in     = pend_valid_ff ? pend_x_ff : 8'd0;
                  rsp_y_in     = pend_valid_ff ? pend_y_ff : 8'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = push | (rsp_valid_ff & ~rsp_ready);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         width_ff      <= SIZE_BITS'(COORD_LIMIT);
         height_ff     <= SIZE_BITS'(COORD_LIMIT);
         issue_done_ff <= 1'b1;
         p_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         issue_done_ff <= issue_done_in;
         p_valid_ff    <= p_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      dxi_ff       <= dxi_in;
      dyi_ff       <= dyi_in;
      p_inb_ff     <= p_inb_in;
      p_center_ff  <= p_center_in;
      p_nx_ff      <= p_nx_in;
      p_ny_ff      <= p_ny_in;
      sums_ff      <= sums_in;
      cnt_ff       <= cnt_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Result port
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_red_out        = rsp_color_ff.red;
   assign rsp_green_out      = rsp_color_ff.green;
   assign rsp_blue_out       = rsp_color_ff.blue;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_last           = rsp_last_ff;

   // Checks
   `NAP_ASSERT_IMPLIES(a_push_has_room, push, out_free)
   `NAP_ASSERT_IMPLIES(a_no_accept_while_clearing, req_ready, !mem_busy)
   `NAP_ASSERT_IMPLIES(a_stall_only_when_full, stall, pend_valid_ff && rsp_valid_ff && !rsp_ready)
   `NAP_ASSERT_IMPLIES(a_no_read_with_write, mem_wr_en, !mem_rd_en)
   `NAP_ASSERT_NEXT(a_scan_exit, scan_end, state_ff == ST_AVG || state_ff == ST_FINISH)

endmodule
